>>> hw/rtl/ra_pkg.sv
// ra_pkg: shared types and constants for the rank_assign block.
// No dependencies.
package ra_pkg;

	localparam int VALUE_W = 32;
	localparam int RANK_W  = 6;

	typedef struct packed {
		logic              vld;
		logic [RANK_W-1:0] cnt;
	} ra_tok_t;

	typedef enum logic [1:0] {
		S_FILL,
		S_FLUSH,
		S_DRAIN
	} ra_state_t;

endpackage

>>> hw/rtl/ra_in_if.sv
// ra_in_if: valid/ready channel carrying one input word (value, last).
// Depends on ra_pkg.
interface ra_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [ra_pkg::VALUE_W-1:0]  value;
	logic                               last;

	modport source (output valid, value, last, input ready);
	modport sink   (input valid, value, last, output ready);
endinterface

>>> hw/rtl/ra_out_if.sv
// ra_out_if: valid/ready channel carrying one result word (rank, final_res, dropped).
// Depends on ra_pkg.
interface ra_out_if;
	logic                        valid;
	logic                        ready;
	logic [ra_pkg::RANK_W-1:0]   rank;
	logic                        final_res;
	logic                        dropped;

	modport source (output valid, rank, final_res, dropped, input ready);
	modport sink   (input valid, rank, final_res, dropped, output ready);
endinterface

>>> hw/rtl/ra_cell.sv
// ra_cell: one slot of the rank chain; holds a key and its running rank,
// compares passing keys and forwards them. Depends on ra_pkg.
module ra_cell #(
	parameter int KEY_W = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift,
	input  ra_pkg::ra_tok_t           tin,
	input  logic [KEY_W-1:0]          tin_key,
	input  logic                      nxt_vld,
	input  logic [ra_pkg::RANK_W-1:0] nxt_cnt,
	output ra_pkg::ra_tok_t           tout,
	output logic [KEY_W-1:0]          tout_key,
	output logic                      vld,
	output logic [ra_pkg::RANK_W-1:0] cnt
);

	logic                      vld_q;
	logic [ra_pkg::RANK_W-1:0] cnt_q;
	logic [KEY_W-1:0]          key_q;
	logic                      tvld_q;
	logic [ra_pkg::RANK_W-1:0] tcnt_q;
	logic [KEY_W-1:0]          tkey_q;
	logic                      land;
	logic                      pass;

	assign land = tin.vld && !vld_q && !shift;
	assign pass = tin.vld && vld_q && !shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			tvld_q <= 1'b0;
		end else begin
			tvld_q <= pass;
			if (shift) begin
				vld_q <= nxt_vld;
			end else if (land) begin
				vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			cnt_q <= nxt_cnt;
		end else if (land) begin
			cnt_q <= tin.cnt;
			key_q <= tin_key;
		end else if (pass && (tin_key < key_q)) begin
			cnt_q <= cnt_q + ra_pkg::RANK_W'(1);
		end
		tkey_q <= tin_key;
		tcnt_q <= tin.cnt + ra_pkg::RANK_W'(key_q < tin_key);
	end

	assign tout.vld = tvld_q;
	assign tout.cnt = tcnt_q;
	assign tout_key = tkey_q;
	assign vld      = vld_q;
	assign cnt      = cnt_q;

endmodule

>>> hw/rtl/rank_assign.sv
// rank_assign: top level; load control, chain of ra_cell slots, rank drain.
// Depends on ra_pkg, ra_in_if, ra_out_if, ra_cell.
//
// Usage:
//   in_ch carries one signed value per word; last closes the set. While a set
//   loads, one word is taken every cycle. The first CAPACITY values enter the
//   chain; later ones are discarded and flag dropped on every rank of the run.
//   Each value walks the cell chain one cell per cycle, counting stored values
//   below it and bumping the ranks of stored values above it.
//   After the word marked last is taken, in_ch.ready stays low. The chain
//   settles while the flush counter runs, then drains: out_ch gives one word
//   per cycle while the receiver takes them, in input order: rank, final_res
//   on the last one, dropped. The chain shifts toward cell 0 on each taken
//   word. When the receiver stalls, the front cell holds and out_ch holds
//   its word. After the final rank is taken, the chain is empty and
//   in_ch.ready rises. Reset empties the chain and clears the fill count and
//   drop flag; no clearing pass is needed.
module rank_assign #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	ra_in_if.sink         in_ch,
	ra_out_if.source      out_ch
);

	localparam int FILL_W = $clog2(CAPACITY + 1);
	localparam int FLW    = $clog2(CAPACITY);

	ra_pkg::ra_state_t state_q, state_nxt;
	logic [FILL_W-1:0] fill_q;
	logic [FLW-1:0]    flush_q;
	logic              ovf_q;

	logic              full;
	logic              in_acc;
	logic              out_acc;
	logic              shift;
	logic              flush_done;
	logic              in_rdy;
	logic              out_vld;

	logic signed [VALUE_BITS-1:0] sval;
	logic [VALUE_BITS-1:0]        key;

	ra_pkg::ra_tok_t            tok [CAPACITY+1];
	logic [VALUE_BITS-1:0]      tok_key [CAPACITY+1];
	logic [CAPACITY:0]          vld;
	logic [ra_pkg::RANK_W-1:0]  cnt [CAPACITY+1];
	logic [CAPACITY-1:0]        tok_vld;

	generate
		if (VALUE_BITS <= ra_pkg::VALUE_W) begin : g_trunc
			assign sval = in_ch.value[VALUE_BITS-1:0];
		end else begin : g_sext
			assign sval = {{(VALUE_BITS-ra_pkg::VALUE_W){in_ch.value[ra_pkg::VALUE_W-1]}},
				in_ch.value};
		end
	endgenerate

	assign key = {~sval[VALUE_BITS-1], sval[VALUE_BITS-2:0]};

	assign full       = (fill_q == FILL_W'(CAPACITY));
	assign in_acc     = in_ch.valid && in_rdy;
	assign out_acc    = out_vld && out_ch.ready;
	assign flush_done = (flush_q == FLW'(CAPACITY - 1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ra_pkg::S_FILL: begin
				if (in_acc && in_ch.last) begin
					state_nxt = ra_pkg::S_FLUSH;
				end
			end
			ra_pkg::S_FLUSH: begin
				if (flush_done) begin
					state_nxt = ra_pkg::S_DRAIN;
				end
			end
			ra_pkg::S_DRAIN: begin
				if (out_acc && !vld[1]) begin
					state_nxt = ra_pkg::S_FILL;
				end
			end
			default: state_nxt = ra_pkg::S_FILL;
		endcase
	end

	always_comb begin
		in_rdy  = 1'b0;
		out_vld = 1'b0;
		case (state_q)
			ra_pkg::S_FILL:  in_rdy  = 1'b1;
			ra_pkg::S_FLUSH: in_rdy  = 1'b0;
			ra_pkg::S_DRAIN: out_vld = vld[0];
			default: begin
				in_rdy  = 1'b0;
				out_vld = 1'b0;
			end
		endcase
	end

	assign shift = out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ra_pkg::S_FILL;
			fill_q  <= '0;
			flush_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ra_pkg::S_FLUSH) begin
				flush_q <= flush_q + FLW'(1);
			end else begin
				flush_q <= '0;
			end
			if (out_acc && !vld[1]) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end else if (in_acc) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	// token injection into the head of the chain
	assign tok[0].vld = in_acc && !full;
	assign tok[0].cnt = '0;
	assign tok_key[0] = key;

	assign vld[CAPACITY] = 1'b0;
	assign cnt[CAPACITY] = '0;

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			ra_cell #(
				.KEY_W (VALUE_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (shift),
				.tin      (tok[i]),
				.tin_key  (tok_key[i]),
				.nxt_vld  (vld[i+1]),
				.nxt_cnt  (cnt[i+1]),
				.tout     (tok[i+1]),
				.tout_key (tok_key[i+1]),
				.vld      (vld[i]),
				.cnt      (cnt[i])
			);
			assign tok_vld[i] = tok[i+1].vld;
		end
	endgenerate

	assign in_ch.ready      = in_rdy;
	assign out_ch.valid     = out_vld;
	assign out_ch.rank      = cnt[0];
	assign out_ch.final_res = !vld[1];
	assign out_ch.dropped   = ovf_q;

`ifndef ASSERT_OFF
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CAPACITY))
		else $error("fill count above capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> full)
		else $error("drop flagged with room left");

	a_no_tok_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ra_pkg::S_DRAIN) |-> (tok_vld == '0))
		else $error("value still moving during drain");

	a_no_falloff: assert property (@(posedge clk) disable iff (!arst_n)
		!tok[CAPACITY].vld)
		else $error("value left the end of the chain");

	a_empty_after: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && out_ch.final_res) |=> (vld == '0) && (fill_q == '0))
		else $error("chain not empty after final rank");

	a_drain_vld: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ra_pkg::S_DRAIN) |-> vld[0])
		else $error("drain with empty front cell");
`endif

endmodule
